@@ hw/rtl/srg_pkg.sv @@
package srg_pkg;

   typedef enum logic [1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_CENTER_Z = 2'd2,
      CSR_RADIUS   = 2'd3
   } csr_index_type;

   localparam int CSR_INDEX_BITS = 2;

endpackage

@@ hw/rtl/srg_core.sv @@
module srg_core #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  logic signed [W-1:0] px,
   input  logic signed [W-1:0] py,
   input  logic signed [W-1:0] pz,
   input  logic signed [W-1:0] cx,
   input  logic signed [W-1:0] cy,
   input  logic signed [W-1:0] cz,
   input  logic [W-2:0]     rad,
   output logic             out_valid,
   output logic [W-1:0]     out_res,
   output logic [F+1:0]     out_gx,
   output logic [F+1:0]     out_gy,
   output logic [F+1:0]     out_gz,
   output logic             out_degen,
   output logic             out_sat
);
   // Front: difference, square, sum (3 stages). Then one stage per root bit
   // (RB stages), rounding, then one stage per quotient bit (QB), rounding.
   localparam int SW = 2 * W + 3;
   localparam int DW = W + 1;
   localparam int MW = W;          // magnitude bits of a difference
   localparam int RB = W + 1;      // root bits (sum < 2^(2W+2))
   localparam int QB = F + 2;      // quotient bits
   localparam int NW = MW + F + 1; // partial remainder width
   localparam int RW = RB + 1;
   localparam int NS = 3 + RB + 1 + QB;

   typedef struct packed {
      logic [MW-1:0] m;
      logic          pos;
   } ax_type;

   // generic per-stage payload
   typedef struct packed {
      ax_type [2:0]   ax;
      logic [SW-1:0]  rem;
      logic [RW-1:0]  root;
      logic [W-2:0]   rad;
      logic [2:0][NW-1:0] n;
      logic [2:0][QB:0]   q;
      logic [W-1:0]   res;
      logic           sat;
      logic           degen;
   } st_type;

   st_type     st_ff [NS+1];
   logic [NS:0] v_ff;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[NS-1:0], in_valid};
   end

   // stage 0: differences
   always_ff @(posedge clock) begin
      if (adv) begin
         logic signed [DW-1:0] d [3];
         st_type s;
         d[0] = DW'(px) - DW'(cx);
         d[1] = DW'(py) - DW'(cy);
         d[2] = DW'(pz) - DW'(cz);
         s = '0;
         for (int i = 0; i < 3; i++) begin
            s.ax[i].pos = d[i] > 0;
            s.ax[i].m = MW'(d[i][DW-1] ? -d[i] : d[i]);
         end
         s.rad = rad;
         st_ff[0] <= s;
      end
   end

   // stage 1: squares (three multipliers, registered)
   logic [2*MW-1:0] sq_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[1] <= st_ff[0];
         for (int i = 0; i < 3; i++)
            sq_ff[i] <= (2*MW)'(st_ff[0].ax[i].m) * (2*MW)'(st_ff[0].ax[i].m);
      end
   end

   // stage 2: sum of squares
   always_ff @(posedge clock) begin
      if (adv) begin
         st_type s;
         s = st_ff[1];
         s.rem = SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
         s.root = '0;
         st_ff[2] <= s;
      end
   end

   // root stages: restoring square root, one bit per stage (no multiplier)
   genvar g;
   generate
      for (g = 0; g < RB; g++) begin : g_root
         localparam int B = RB - 1 - g;
         always_ff @(posedge clock) begin
            if (adv) begin
               logic [SW+1:0] t;
               st_type s;
               s = st_ff[2+g];
               // trial: (2*root*2^B + 2^(2B))  with root holding high bits
               t = ((SW+2)'(s.root) << (B + 1)) + ((SW+2)'(1) << (2 * B));
               if ((SW+2)'(s.rem) >= t) begin
                  s.rem = SW'((SW+2)'(s.rem) - t);
                  s.root = s.root | (RW'(1) << B);
               end
               st_ff[3+g] <= s;
            end
         end
      end
   endgenerate

   localparam int RS = 3 + RB; // after rounding stage index
   // rounding, residual, gradient setup
   always_ff @(posedge clock) begin
      if (adv) begin
         st_type s;
         logic signed [RW+1:0] r;
         logic signed [RW+1:0] hi;
         logic signed [RW+1:0] lo;
         s = st_ff[RS-1];
         if ((SW+1)'(s.rem) > (SW+1)'(s.root)) s.root = s.root + 1'b1;
         s.degen = s.root == '0;
         hi = (RW+2)'({1'b0, {(W-1){1'b1}}});
         lo = -hi - 1'b1;
         r = (RW+2)'(s.root) - (RW+2)'(s.rad);
         s.sat = 1'b0;
         if (r > hi) begin r = hi; s.sat = 1'b1; end
         if (r < lo) begin r = lo; s.sat = 1'b1; end
         s.res = W'(r);
         for (int i = 0; i < 3; i++) begin
            s.n[i] = NW'(s.ax[i].m) << F;
            s.q[i] = '0;
         end
         st_ff[RS] <= s;
      end
   end

   // quotient stages: restoring division, one bit per stage for each axis
   generate
      for (g = 0; g < QB; g++) begin : g_div
         localparam int B = QB - 1 - g;
         always_ff @(posedge clock) begin
            if (adv) begin
               st_type s;
               logic [NW+RW:0] t;
               s = st_ff[RS+g];
               t = (NW+RW+1)'(s.root) << B;
               for (int i = 0; i < 3; i++) begin
                  if ((NW+RW+1)'(s.n[i]) >= t) begin
                     s.n[i] = NW'((NW+RW+1)'(s.n[i]) - t);
                     s.q[i][B] = 1'b1;
                  end
               end
               st_ff[RS+1+g] <= s;
            end
         end
      end
   endgenerate

   localparam int LS = RS + 1 + QB;
   always_ff @(posedge clock) begin
      if (adv) begin
         st_type s;
         s = st_ff[LS-1];
         for (int i = 0; i < 3; i++) begin
            if ((NW+2)'(s.n[i]) * 2 >= (NW+2)'(s.root)) s.q[i] = s.q[i] + 1'b1;
            if (s.q[i] > (QB+1)'(1 << F)) s.q[i] = (QB+1)'(1 << F);
            if (s.degen || s.ax[i].m == '0) s.q[i] = '0;
            else if (s.ax[i].pos) s.q[i] = -s.q[i];
         end
         st_ff[LS] <= s;
      end
   end

   assign out_valid = v_ff[LS];
   assign out_res = st_ff[LS].res;
   assign out_gx = st_ff[LS].q[0][F+1:0];
   assign out_gy = st_ff[LS].q[1][F+1:0];
   assign out_gz = st_ff[LS].q[2][F+1:0];
   assign out_degen = st_ff[LS].degen;
   assign out_sat = st_ff[LS].sat;
endmodule

@@ hw/rtl/sphere_residual_gradient.sv @@
// Point-to-sphere residual and centre gradient. A point passes through 3 front
// stages, COORD_BITS+1 square-root stages, 1 rounding stage, FRAC_BITS+2
// divider stages and 1 output stage. The whole pipe advances when the output
// slot is empty or being taken, so throughput is one point a cycle while the
// output is not stalled by a held result with rsp_tready low.
module sphere_residual_gradient #(
   parameter int FRAC_BITS  = 16,
   parameter int COORD_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // point_x, point_y, point_z
   input  logic [3*COORD_BITS-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // residual, grad_x, grad_y, grad_z, degenerate, saturated, zero fill
   output logic [((COORD_BITS+3*(FRAC_BITS+2)+2+7)/8)*8-1:0] rsp_tdata,
   input  logic csr_wr_en,
   input  logic [srg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0] csr_wdata
);
   localparam int W = COORD_BITS;
   localparam int G = FRAC_BITS + 2;
   localparam int PW = W + 3 * G + 2;
   localparam int TW = ((PW + 7) / 8) * 8;

   logic signed [W-1:0] cx_ff, cy_ff, cz_ff;
   logic [W-2:0] rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
         cz_ff <= '0;
         rad_ff <= (W-1)'(1) << FRAC_BITS;
      end else if (csr_wr_en) begin
         case (srg_pkg::csr_index_type'(csr_index))
            srg_pkg::CSR_CENTER_X: cx_ff <= csr_wdata;
            srg_pkg::CSR_CENTER_Y: cy_ff <= csr_wdata;
            srg_pkg::CSR_CENTER_Z: cz_ff <= csr_wdata;
            srg_pkg::CSR_RADIUS:   rad_ff <= csr_wdata[W-2:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic o_valid, o_degen, o_sat;
   logic [W-1:0] o_res;
   logic [G-1:0] o_gx, o_gy, o_gz;

   // advance when the last stage is empty or drained this cycle
   assign adv = !o_valid || rsp_tready;
   assign req_tready = adv;

   srg_core #(.W(W), .F(FRAC_BITS)) u_core (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(req_tvalid),
      .px(req_tdata[W-1:0]), .py(req_tdata[2*W-1:W]), .pz(req_tdata[3*W-1:2*W]),
      .cx(cx_ff), .cy(cy_ff), .cz(cz_ff), .rad(rad_ff),
      .out_valid(o_valid), .out_res(o_res),
      .out_gx(o_gx), .out_gy(o_gy), .out_gz(o_gz),
      .out_degen(o_degen), .out_sat(o_sat)
   );

   assign rsp_tvalid = o_valid;
   assign rsp_tdata = TW'({o_sat, o_degen, o_gz, o_gy, o_gx, o_res});

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("stalled with empty output");
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[PW-2] |-> rsp_tdata[W+3*G-1:W] == '0)
      else $error("degenerate result with nonzero gradient");
endmodule
